[sv/mbsc_pkg.sv]
`timescale 1ns / 1ps

package mbsc_pkg;

  localparam int WORD_BITS  = 64;
  localparam int IN_WORD_W  = 64;
  localparam int OUT_WORD_W = 64;
  localparam int VALID_W    = 7;
  localparam int OUT_CNT_W  = 7;

  localparam int LANE_BITS  = 8;
  localparam int NUM_LANES  = WORD_BITS / LANE_BITS;
  localparam int LANE_CNT_W = $clog2(LANE_BITS + 1);
  localparam int LANE_IDX_W = $clog2(LANE_BITS);

  localparam int CNT_W  = $clog2(WORD_BITS + 1);
  localparam int FILL_W = $clog2(WORD_BITS);
  localparam int SUM_W  = CNT_W + 1;

  // up to two results per item
  localparam int RES_PER_ITEM = 2;
  localparam int FIFO_DEPTH   = 8;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [LANE_BITS-1:0]  bits;
    logic [LANE_CNT_W-1:0] cnt;
  } lane_res_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] bits;
    logic [CNT_W-1:0]     cnt;
  } pext_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

  typedef struct packed {
    logic [OUT_WORD_W-1:0] word;
    logic [OUT_CNT_W-1:0]  cnt;
    logic                  eos;
  } out_entry_t;

endpackage

[sv/mbsc_lane.sv]
`timescale 1ns / 1ps

module mbsc_lane (
  input  logic                          clk,
  input  logic [mbsc_pkg::LANE_BITS-1:0] data,
  input  logic [mbsc_pkg::LANE_BITS-1:0] keep,
  output mbsc_pkg::lane_res_t           res
);
  import mbsc_pkg::*;

  lane_res_t res_nxt;
  lane_res_t res_r;

  // local bit extract over one slice
  always_comb begin
    res_nxt = '0;
    for (int i = 0; i < LANE_BITS; i++) begin
      if (keep[i]) begin
        res_nxt.bits[res_nxt.cnt[LANE_IDX_W-1:0]] = data[i];
        res_nxt.cnt = res_nxt.cnt + LANE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

[sv/mbsc_merge.sv]
`timescale 1ns / 1ps

module mbsc_merge (
  input  logic                clk,
  input  mbsc_pkg::lane_res_t lanes [mbsc_pkg::NUM_LANES],
  output mbsc_pkg::pext_t     pext
);
  import mbsc_pkg::*;

  pext_t pext_nxt;
  pext_t pext_r;

  // place each lane's kept bits behind those of the lanes below it
  always_comb begin
    pext_nxt = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      pext_nxt.bits = pext_nxt.bits | (WORD_BITS'(lanes[l].bits) << pext_nxt.cnt);
      pext_nxt.cnt  = pext_nxt.cnt + CNT_W'(lanes[l].cnt);
    end
  end

  always_ff @(posedge clk) begin
    pext_r <= pext_nxt;
  end

  assign pext = pext_r;

endmodule

[sv/mbsc_pack.sv]
`timescale 1ns / 1ps

module mbsc_pack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mbsc_pkg::stage_ctrl_t               ctrl,
  input  mbsc_pkg::pext_t                     pext,
  output logic [mbsc_pkg::FIFO_CNT_W-1:0]     fifo_cnt,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mbsc_pkg::OUT_WORD_W-1:0]     out_packed_word,
  output logic [mbsc_pkg::OUT_CNT_W-1:0]      out_bit_count,
  output logic                                out_end_of_stream
);
  import mbsc_pkg::*;

  logic [WORD_BITS-1:0]   acc_r, acc_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [2*WORD_BITS-1:0] combined;
  logic [SUM_W-1:0]       sum;
  logic                   full;
  logic [WORD_BITS-1:0]   rem;
  logic [FILL_W-1:0]      rem_fill;
  out_entry_t             full_e, final_e, e0, e1;
  logic                   wr0, wr1, pop;

  out_entry_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    combined = {{WORD_BITS{1'b0}}, acc_r} | ({{WORD_BITS{1'b0}}, pext.bits} << fill_r);
    sum      = SUM_W'(fill_r) + SUM_W'(pext.cnt);
    full     = sum >= SUM_W'(WORD_BITS);
    rem      = full ? combined[2*WORD_BITS-1:WORD_BITS] : combined[WORD_BITS-1:0];
    rem_fill = full ? FILL_W'(sum - SUM_W'(WORD_BITS)) : FILL_W'(sum);

    full_e.word  = OUT_WORD_W'(combined[WORD_BITS-1:0]);
    full_e.cnt   = OUT_CNT_W'(WORD_BITS);
    full_e.eos   = 1'b0;
    final_e.word = OUT_WORD_W'(rem);
    final_e.cnt  = OUT_CNT_W'(rem_fill);
    final_e.eos  = 1'b1;

    wr0 = ctrl.valid && (full || ctrl.last);
    wr1 = ctrl.valid && full && ctrl.last;
    e0  = full ? full_e : final_e;
    e1  = final_e;

    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    if (ctrl.valid) begin
      if (ctrl.last) begin
        acc_nxt  = '0;
        fill_nxt = '0;
      end else begin
        acc_nxt  = rem;
        fill_nxt = rem_fill;
      end
    end

    pop        = out_valid && !out_stall;
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + PTR_W'(1)) : rd_ptr_r;
    wr_ptr_nxt = PTR_W'(wr_ptr_r + PTR_W'(wr0) + PTR_W'(wr1));
    cnt_nxt    = FIFO_CNT_W'(cnt_r + FIFO_CNT_W'(wr0) + FIFO_CNT_W'(wr1) - FIFO_CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      fill_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      acc_r    <= acc_nxt;
      fill_r   <= fill_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr0) begin
      fifo_r[wr_ptr_r] <= e0;
    end
    if (wr1) begin
      fifo_r[PTR_W'(wr_ptr_r + PTR_W'(1))] <= e1;
    end
  end

  assign fifo_cnt          = cnt_r;
  assign out_valid         = cnt_r != '0;
  assign out_packed_word   = fifo_r[rd_ptr_r].word;
  assign out_bit_count     = fifo_r[rd_ptr_r].cnt;
  assign out_end_of_stream = fifo_r[rd_ptr_r].eos;

endmodule

[sv/masked_bit_stream_compactor_top.sv]
// accepted words pass the lane and merge registers, then the queue that feeds the out_ ports
// throughput: one input word per cycle, up to two result words per input, and one result
//   leaves per cycle while out_stall is low; input stalls only when the 8-entry result queue
//   could not take the worst case of the next word and of those in the lane and merge stages
// reset (rst_n low, synchronous) empties the pipeline and queue and clears the accumulator
`timescale 1ns / 1ps

module masked_bit_stream_compactor_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mbsc_pkg::IN_WORD_W-1:0]    in_data_bits,
  input  logic [mbsc_pkg::IN_WORD_W-1:0]    in_keep_mask,
  input  logic [mbsc_pkg::VALID_W-1:0]      in_valid_bits,
  input  logic                              in_is_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mbsc_pkg::OUT_WORD_W-1:0]   out_packed_word,
  output logic [mbsc_pkg::OUT_CNT_W-1:0]    out_bit_count,
  output logic                              out_end_of_stream
);
  import mbsc_pkg::*;

  localparam int RESV_W = FIFO_CNT_W + 2;

  logic [VALID_W-1:0]    vsat;
  logic [WORD_BITS-1:0]  vmask, keep_eff, data_eff;
  logic                  in_acc;
  lane_res_t             lane_res [NUM_LANES];
  pext_t                 pext;
  stage_ctrl_t           s1_r, s1_nxt, s2_r;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [RESV_W-1:0]     resv;

  always_comb begin
    vsat = (in_valid_bits > VALID_W'(WORD_BITS)) ? VALID_W'(WORD_BITS) : in_valid_bits;
    for (int i = 0; i < WORD_BITS; i++) begin
      vmask[i] = VALID_W'(i) < vsat;
    end
    data_eff = in_data_bits[WORD_BITS-1:0];
    keep_eff = in_keep_mask[WORD_BITS-1:0] & vmask;
  end

  // room for the worst case of every word in flight plus the next one
  always_comb begin
    resv = RESV_W'(fifo_cnt)
         + RESV_W'(RES_PER_ITEM) * (RESV_W'(s1_r.valid) + RESV_W'(s2_r.valid))
         + RESV_W'(RES_PER_ITEM);
    in_stall = resv > RESV_W'(FIFO_DEPTH);
  end

  assign in_acc       = in_valid && !in_stall;
  assign s1_nxt.valid = in_acc;
  assign s1_nxt.last  = in_is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    mbsc_lane u_lane (
      .clk  (clk),
      .data (data_eff[l*LANE_BITS +: LANE_BITS]),
      .keep (keep_eff[l*LANE_BITS +: LANE_BITS]),
      .res  (lane_res[l])
    );
  end

  mbsc_merge u_merge (
    .clk   (clk),
    .lanes (lane_res),
    .pext  (pext)
  );

  mbsc_pack u_pack (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (s2_r),
    .pext              (pext),
    .fifo_cnt          (fifo_cnt),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packed_word   (out_packed_word),
    .out_bit_count     (out_bit_count),
    .out_end_of_stream (out_end_of_stream)
  );

endmodule
